[src/hcbd_pkg.sv]
package hcbd_pkg;

  // field widths
  localparam int unsigned TOTAL_W = 48;
  localparam int unsigned ACC_W   = 64;

  // result kinds
  localparam logic [1:0] KIND_DATA = 2'd0;
  localparam logic [1:0] KIND_DONE = 2'd1;
  localparam logic [1:0] KIND_ERR  = 2'd2;

  // error codes
  localparam logic [2:0] ERR_NONE     = 3'd0;
  localparam logic [2:0] ERR_BAD_SIZE = 3'd1;
  localparam logic [2:0] ERR_CRLF     = 3'd2;
  localparam logic [2:0] ERR_TOO_BIG  = 3'd3;
  localparam logic [2:0] ERR_LINE     = 3'd4;
  localparam logic [2:0] ERR_EOF      = 3'd5;

  // input actions
  localparam logic ACT_BYTE  = 1'b0;
  localparam logic ACT_CLOSE = 1'b1;

  // one input item
  typedef struct packed {
    logic       action;
    logic [7:0] in_byte;
  } item_t;

  // one result item
  typedef struct packed {
    logic [1:0]         kind;
    logic [7:0]         out_byte;
    logic [2:0]         error_code;
    logic [TOTAL_W-1:0] total_bytes;
  } result_t;

  // valid plus payload between stages
  typedef struct packed {
    logic  vld;
    item_t item;
  } item_slot_t;

  typedef struct packed {
    logic    vld;
    result_t res;
  } result_slot_t;

endpackage

[src/hcbd_if.sv]
// received byte stream
interface hcbd_in_if;
  logic       valid;
  logic       ready;
  logic       action;
  logic [7:0] in_byte;

  modport source (output valid, output action, output in_byte, input ready);
  modport sink (input valid, input action, input in_byte, output ready);
endinterface

// decoded body stream
interface hcbd_out_if;
  logic                        valid;
  logic                        ready;
  logic [1:0]                  kind;
  logic [7:0]                  out_byte;
  logic [2:0]                  error_code;
  logic [hcbd_pkg::TOTAL_W-1:0] total_bytes;

  modport source (output valid, output kind, output out_byte, output error_code,
                  output total_bytes, input ready);
  modport sink (input valid, input kind, input out_byte, input error_code,
                input total_bytes, output ready);
endinterface

// body limit register write
interface hcbd_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [hcbd_pkg::TOTAL_W-1:0] max_body_bytes;

  modport source (output valid, output max_body_bytes, input ready);
  modport sink (input valid, input max_body_bytes, output ready);
endinterface

[src/hcbd_in_stage.sv]
module hcbd_in_stage (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  hcbd_pkg::item_t      in_item_i,
  output logic                 in_ready_o,
  input  logic                 advance_i,
  output hcbd_pkg::item_slot_t slot_o
);

  logic            vld_q, vld_d;
  hcbd_pkg::item_t item_q;

  // slot is free when empty or draining this cycle
  assign in_ready_o = !vld_q || advance_i;
  assign vld_d      = in_ready_o ? in_valid_i : vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  // payload capture on transfer
  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      item_q <= in_item_i;
    end
  end

  assign slot_o.vld  = vld_q;
  assign slot_o.item = item_q;

endmodule

[src/hcbd_parser.sv]
module hcbd_parser #(
  parameter int unsigned SIZE_LINE_MAX    = 64,
  parameter int unsigned TRAILER_LINE_MAX = 65536
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  hcbd_pkg::item_slot_t          slot_i,
  input  logic                          advance_i,
  input  logic                          cfg_valid_i,
  input  logic [hcbd_pkg::TOTAL_W-1:0]  cfg_data_i,
  output hcbd_pkg::result_slot_t        res_o
);

  localparam int unsigned LINE_MAX =
    (SIZE_LINE_MAX > TRAILER_LINE_MAX) ? SIZE_LINE_MAX : TRAILER_LINE_MAX;
  localparam int unsigned LEN_W = $clog2(LINE_MAX + 1);
  localparam int unsigned TW    = hcbd_pkg::TOTAL_W;
  localparam int unsigned AW    = hcbd_pkg::ACC_W;

  localparam logic [7:0] CH_CR   = 8'h0d;
  localparam logic [7:0] CH_LF   = 8'h0a;
  localparam logic [7:0] CH_SEMI = 8'h3b;

  typedef enum logic [3:0] {
    PH_HEX, PH_HEX_CR, PH_EXT, PH_EXT_CR, PH_DATA, PH_END1, PH_END2,
    PH_TRL, PH_TRL_CR, PH_DONE, PH_ERR
  } phase_e;

  phase_e          phase_q, phase_d;
  logic [AW-1:0]   acc_q, acc_d;
  logic            digit_q, digit_d;
  logic [LEN_W-1:0] len_q, len_d;
  logic [AW-1:0]   left_q, left_d;
  logic [TW-1:0]   total_q, total_d;
  logic            trl_q, trl_d;
  logic [2:0]      serr_q, serr_d;
  logic [TW-1:0]   max_q;
  logic [TW-1:0]   headroom_q;
  logic            over_q;

  // hex digit decode, bit 4 flags a valid digit
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, 4'(c - 8'h30)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r = {1'b1, 4'(c - 8'h57)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r = {1'b1, 4'(c - 8'h37)};
    end
    return r;
  endfunction

  logic       step;
  logic [7:0] c;
  logic [4:0] hd;
  logic [LEN_W-1:0] limit;

  assign step = slot_i.vld && advance_i;
  assign c    = slot_i.item.in_byte;
  assign hd   = hex_digit(c);
  assign limit = (phase_q == PH_TRL || phase_q == PH_TRL_CR) ?
                 LEN_W'(TRAILER_LINE_MAX) : LEN_W'(SIZE_LINE_MAX);

  // one step of the decoder per item
  always_comb begin
    phase_d = phase_q;
    acc_d   = acc_q;
    digit_d = digit_q;
    len_d   = len_q;
    left_d  = left_q;
    total_d = total_q;
    trl_d   = trl_q;
    serr_d  = serr_q;
    res_o.vld             = 1'b0;
    res_o.res.kind        = hcbd_pkg::KIND_DATA;
    res_o.res.out_byte    = 8'd0;
    res_o.res.error_code  = hcbd_pkg::ERR_NONE;
    res_o.res.total_bytes = total_q;

    if (step && phase_q != PH_DONE && phase_q != PH_ERR) begin
      if (slot_i.item.action == hcbd_pkg::ACT_CLOSE) begin
        phase_d = PH_ERR;
        res_o.vld = 1'b1;
        res_o.res.kind = hcbd_pkg::KIND_ERR;
        res_o.res.error_code = hcbd_pkg::ERR_EOF;
      end else begin
        case (phase_q)
          PH_DATA: begin
            if (total_q != {TW{1'b1}}) begin
              total_d = total_q + TW'(1);
            end
            left_d = left_q - AW'(1);
            if (left_q == AW'(1)) begin
              phase_d = PH_END1;
            end
            res_o.vld = 1'b1;
            res_o.res.out_byte = c;
            res_o.res.total_bytes = total_d;
          end
          PH_END1: begin
            serr_d  = (c == CH_CR) ? hcbd_pkg::ERR_NONE : hcbd_pkg::ERR_CRLF;
            phase_d = PH_END2;
          end
          PH_END2: begin
            if (serr_q != hcbd_pkg::ERR_NONE || c != CH_LF) begin
              phase_d = PH_ERR;
              res_o.vld = 1'b1;
              res_o.res.kind = hcbd_pkg::KIND_ERR;
              res_o.res.error_code = hcbd_pkg::ERR_CRLF;
            end else begin
              len_d = '0; acc_d = '0; digit_d = 1'b0; serr_d = hcbd_pkg::ERR_NONE;
              trl_d = 1'b0;
              phase_d = PH_HEX;
            end
          end
          default: begin
            if (c == CH_LF && (phase_q == PH_HEX_CR || phase_q == PH_EXT_CR)) begin
              // end of the size line
              if (serr_q != hcbd_pkg::ERR_NONE || !digit_q) begin
                phase_d = PH_ERR;
                res_o.vld = 1'b1;
                res_o.res.kind = hcbd_pkg::KIND_ERR;
                res_o.res.error_code = hcbd_pkg::ERR_BAD_SIZE;
              end else begin
                len_d = '0; acc_d = '0; digit_d = 1'b0; serr_d = hcbd_pkg::ERR_NONE;
                trl_d = 1'b0;
                if (acc_q == '0) begin
                  phase_d = PH_TRL;
                end else if (max_q != '0 &&
                             (over_q || acc_q > {{(AW-TW){1'b0}}, headroom_q})) begin
                  phase_d = PH_ERR;
                  res_o.vld = 1'b1;
                  res_o.res.kind = hcbd_pkg::KIND_ERR;
                  res_o.res.error_code = hcbd_pkg::ERR_TOO_BIG;
                end else begin
                  left_d  = acc_q;
                  phase_d = PH_DATA;
                end
              end
            end else if (c == CH_LF && phase_q == PH_TRL_CR) begin
              // end of a trailer line, an empty one closes the body
              if (!trl_q) begin
                phase_d = PH_DONE;
                res_o.vld = 1'b1;
                res_o.res.kind = hcbd_pkg::KIND_DONE;
              end else begin
                len_d = '0; acc_d = '0; digit_d = 1'b0; serr_d = hcbd_pkg::ERR_NONE;
                trl_d = 1'b0;
                phase_d = PH_TRL;
              end
            end else if (len_q >= limit) begin
              phase_d = PH_ERR;
              res_o.vld = 1'b1;
              res_o.res.kind = hcbd_pkg::KIND_ERR;
              res_o.res.error_code = hcbd_pkg::ERR_LINE;
            end else begin
              len_d = len_q + LEN_W'(1);
              case (phase_q)
                PH_HEX, PH_HEX_CR: begin
                  // a lone cr in the size line marks it bad
                  if (phase_q == PH_HEX_CR) begin
                    serr_d  = hcbd_pkg::ERR_BAD_SIZE;
                    phase_d = PH_HEX;
                  end
                  if (hd[4]) begin
                    if (acc_q[AW-1:AW-4] != 4'd0) begin
                      serr_d = hcbd_pkg::ERR_BAD_SIZE;
                    end else begin
                      acc_d   = {acc_q[AW-5:0], hd[3:0]};
                      digit_d = 1'b1;
                    end
                  end else if (c == CH_SEMI) begin
                    phase_d = PH_EXT;
                  end else if (c == CH_CR) begin
                    phase_d = PH_HEX_CR;
                  end else begin
                    serr_d = hcbd_pkg::ERR_BAD_SIZE;
                  end
                end
                PH_EXT, PH_EXT_CR: begin
                  phase_d = (c == CH_CR) ? PH_EXT_CR : PH_EXT;
                end
                PH_TRL_CR: begin
                  trl_d   = 1'b1;
                  phase_d = (c == CH_CR) ? PH_TRL_CR : PH_TRL;
                end
                default: begin
                  if (c == CH_CR) begin
                    phase_d = PH_TRL_CR;
                  end else begin
                    trl_d = 1'b1;
                  end
                end
              endcase
            end
          end
        endcase
      end
    end
  end

  // decoder state and limit register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_HEX;
      acc_q      <= '0;
      digit_q    <= 1'b0;
      len_q      <= '0;
      left_q     <= '0;
      total_q    <= '0;
      trl_q      <= 1'b0;
      serr_q     <= hcbd_pkg::ERR_NONE;
      max_q      <= '0;
      headroom_q <= '0;
      over_q     <= 1'b0;
    end else begin
      phase_q <= phase_d;
      acc_q   <= acc_d;
      digit_q <= digit_d;
      len_q   <= len_d;
      left_q  <= left_d;
      total_q <= total_d;
      trl_q   <= trl_d;
      serr_q  <= serr_d;
      if (cfg_valid_i) begin
        max_q <= cfg_data_i;
      end
      // room left under the limit; after a data byte it is ready before any size line can end
      headroom_q <= max_q - total_q;
      over_q     <= total_q > max_q;
    end
  end

endmodule

[src/hcbd_out_stage.sv]
module hcbd_out_stage (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  hcbd_pkg::result_slot_t res_i,
  output logic                   advance_o,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output hcbd_pkg::result_t      out_res_o
);

  logic              vld_q, vld_d;
  hcbd_pkg::result_t res_q;

  // result register takes a new value when empty or being drained
  assign advance_o = !vld_q || out_ready_i;
  assign vld_d     = advance_o ? res_i.vld : vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_o && res_i.vld) begin
      res_q <= res_i.res;
    end
  end

  assign out_valid_o = vld_q;
  assign out_res_o   = res_q;

endmodule

[src/http_chunked_body_decoder_core.sv]
// channel  dir  handshake      payload
// in_i     in   valid/ready    action, in_byte
// out_o    out  valid/ready    kind, out_byte, error_code, total_bytes
// cfg_i    in   valid/ready    max_body_bytes (ready is always high)
//
// one byte per cycle unless stalled: input register, one decode step, result register
// a result passes the input register, then the result register
// reset clears all decoder state and the body limit; no clearing pass
// an output stall holds the result register and backs up into the input register
module http_chunked_body_decoder_core #(
  parameter int unsigned SIZE_LINE_MAX    = 64,
  parameter int unsigned TRAILER_LINE_MAX = 65536
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  hcbd_in_if.sink     in_i,
  hcbd_out_if.source  out_o,
  hcbd_cfg_if.sink    cfg_i
);

  hcbd_pkg::item_t        in_item;
  hcbd_pkg::item_slot_t   slot;
  hcbd_pkg::result_slot_t res;
  hcbd_pkg::result_t      out_res;
  logic                   advance;
  logic                   in_ready;
  logic                   out_valid;

  assign in_item.action  = in_i.action;
  assign in_item.in_byte = in_i.in_byte;
  assign in_i.ready      = in_ready;
  assign cfg_i.ready     = 1'b1;

  hcbd_in_stage u_in (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_item_i  (in_item),
    .in_ready_o (in_ready),
    .advance_i  (advance),
    .slot_o     (slot)
  );

  hcbd_parser #(
    .SIZE_LINE_MAX    (SIZE_LINE_MAX),
    .TRAILER_LINE_MAX (TRAILER_LINE_MAX)
  ) u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .slot_i      (slot),
    .advance_i   (advance),
    .cfg_valid_i (cfg_i.valid),
    .cfg_data_i  (cfg_i.max_body_bytes),
    .res_o       (res)
  );

  hcbd_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_i       (res),
    .advance_o   (advance),
    .out_valid_o (out_valid),
    .out_ready_i (out_o.ready),
    .out_res_o   (out_res)
  );

  assign out_o.valid       = out_valid;
  assign out_o.kind        = out_res.kind;
  assign out_o.out_byte    = out_res.out_byte;
  assign out_o.error_code  = out_res.error_code;
  assign out_o.total_bytes = out_res.total_bytes;

endmodule

[src/hcbd_checker.sv]
module hcbd_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         out_valid_i,
  input logic                         out_ready_i,
  input logic [1:0]                   kind_i,
  input logic [2:0]                   error_code_i,
  input logic [hcbd_pkg::TOTAL_W-1:0] total_bytes_i
);

  localparam int unsigned TW = hcbd_pkg::TOTAL_W;

  logic          seen_q;
  logic [TW-1:0] last_q;
  logic          xfer;
  logic [TW-1:0] expect_total;

  assign xfer = out_valid_i && out_ready_i;
  assign expect_total = (last_q == {TW{1'b1}}) ? last_q : last_q + TW'(1);

  // track the total of the last data transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q <= 1'b0;
      last_q <= '0;
    end else if (xfer && kind_i == hcbd_pkg::KIND_DATA) begin
      seen_q <= 1'b1;
      last_q <= total_bytes_i;
    end
  end

  // a stalled result stays valid with its kind and total unchanged
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(kind_i) &&
    $stable(total_bytes_i))
    else $error("result changed while stalled");

  // nothing follows completion or an error
  a_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    xfer && (kind_i == hcbd_pkg::KIND_DONE || kind_i == hcbd_pkg::KIND_ERR)
    |=> !out_valid_i)
    else $error("result after completion or error");

  // each data byte adds one to the running total
  a_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    xfer && kind_i == hcbd_pkg::KIND_DATA && seen_q |-> total_bytes_i == expect_total)
    else $error("total did not advance by one");

  // error code present exactly on error results
  a_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> ((kind_i == hcbd_pkg::KIND_ERR) ==
                     (error_code_i != hcbd_pkg::ERR_NONE)))
    else $error("error code does not match kind");

endmodule

bind http_chunked_body_decoder_core hcbd_checker u_hcbd_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .kind_i        (out_o.kind),
  .error_code_i  (out_o.error_code),
  .total_bytes_i (out_o.total_bytes)
);

[sim/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned SIZE_LINE_MAX    = 64;
  localparam int unsigned TRAILER_LINE_MAX = 65536;
  localparam int unsigned TOTAL_W          = hcbd_pkg::TOTAL_W;
  localparam int unsigned ACC_W            = hcbd_pkg::ACC_W;

  localparam logic [7:0]          CH_CR         = 8'h0D;
  localparam logic [7:0]          CH_LF         = 8'h0A;
  localparam logic [TOTAL_W-1:0]  TOTAL_MAX     = '1;
  localparam logic [ACC_W-1:0]    ACC_SHIFT_MAX = 64'h0FFF_FFFF_FFFF_FFFF;
  localparam hcbd_pkg::result_t   NO_RES        = '0;

  // decoder phases of the local copy
  typedef enum logic [3:0] {
    S_HEX, S_HEX_CR, S_EXT, S_EXT_CR, S_DATA, S_END1, S_END2,
    S_TRL, S_TRL_CR, S_DONE, S_ERR
  } dec_state_e;

  // one directed row: stimulus plus an optional hand-written expectation
  typedef struct packed {
    hcbd_pkg::item_t   stim;
    logic              typed;
    logic              has_res;
    hcbd_pkg::result_t res;
  } dir_row_t;

  localparam int DIR_N = 19;

  // "002;<ff><cr>x" + CRLF, two data bytes at the byte extremes, then a
  // one-byte chunk carrying a CR as data
  dir_row_t dir_tab [DIR_N] = '{
    {hcbd_pkg::ACT_BYTE, 8'h30, 1'b0, 1'b0, NO_RES},
    {hcbd_pkg::ACT_BYTE, 8'h30, 1'b0, 1'b0, NO_RES},
    {hcbd_pkg::ACT_BYTE, 8'h32, 1'b0, 1'b0, NO_RES},
    {hcbd_pkg::ACT_BYTE, 8'h3B, 1'b0, 1'b0, NO_RES},
    {hcbd_pkg::ACT_BYTE, 8'hFF, 1'b0, 1'b0, NO_RES},
    {hcbd_pkg::ACT_BYTE, CH_CR, 1'b0, 1'b0, NO_RES},
    {hcbd_pkg::ACT_BYTE, 8'h78, 1'b0, 1'b0, NO_RES},
    {hcbd_pkg::ACT_BYTE, CH_CR, 1'b0, 1'b0, NO_RES},
    {hcbd_pkg::ACT_BYTE, CH_LF, 1'b0, 1'b0, NO_RES},
    {hcbd_pkg::ACT_BYTE, 8'h00, 1'b1, 1'b1,
     {hcbd_pkg::KIND_DATA, 8'h00, hcbd_pkg::ERR_NONE, 48'd1}},
    {hcbd_pkg::ACT_BYTE, 8'hFF, 1'b1, 1'b1,
     {hcbd_pkg::KIND_DATA, 8'hFF, hcbd_pkg::ERR_NONE, 48'd2}},
    {hcbd_pkg::ACT_BYTE, CH_CR, 1'b1, 1'b0, NO_RES},
    {hcbd_pkg::ACT_BYTE, CH_LF, 1'b1, 1'b0, NO_RES},
    {hcbd_pkg::ACT_BYTE, 8'h31, 1'b0, 1'b0, NO_RES},
    {hcbd_pkg::ACT_BYTE, CH_CR, 1'b0, 1'b0, NO_RES},
    {hcbd_pkg::ACT_BYTE, CH_LF, 1'b0, 1'b0, NO_RES},
    {hcbd_pkg::ACT_BYTE, CH_CR, 1'b1, 1'b1,
     {hcbd_pkg::KIND_DATA, CH_CR, hcbd_pkg::ERR_NONE, 48'd3}},
    {hcbd_pkg::ACT_BYTE, CH_CR, 1'b1, 1'b0, NO_RES},
    {hcbd_pkg::ACT_BYTE, CH_LF, 1'b1, 1'b0, NO_RES}
  };

  logic clk_i = 1'b0;
  logic rst_ni;

  hcbd_in_if  in_if ();
  hcbd_out_if out_if ();
  hcbd_cfg_if cfg_if ();

  http_chunked_body_decoder_core u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  // clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // local copy of the decoder state
  dec_state_e         st;
  logic [ACC_W-1:0]   size_acc;
  logic               have_digit;
  int unsigned        line_len;
  logic [ACC_W-1:0]   chunk_left;
  logic [TOTAL_W-1:0] body_total;
  logic               trl_content;
  logic [2:0]         pend_err;
  logic [TOTAL_W-1:0] body_limit;

  hcbd_pkg::result_t body_q [$];
  int unsigned errors       = 0;
  int unsigned results_seen = 0;
  int unsigned items_sent   = 0;
  int unsigned burst_left   = 0;

  // append one expected result
  function automatic void note_result(hcbd_pkg::result_t r);
    body_q = {body_q, r};
  endfunction

  // fresh size or trailer line
  function automatic void start_line();
    line_len    = 0;
    size_acc    = '0;
    have_digit  = 1'b0;
    pend_err    = hcbd_pkg::ERR_NONE;
    trl_content = 1'b0;
  endfunction

  function automatic hcbd_pkg::result_t make_res(logic [1:0] k, logic [7:0] b,
                                                 logic [2:0] e);
    hcbd_pkg::result_t r;
    r.kind        = k;
    r.out_byte    = b;
    r.error_code  = e;
    r.total_bytes = body_total;
    return r;
  endfunction

  function automatic hcbd_pkg::result_t abort(logic [2:0] e);
    st = S_ERR;
    return make_res(hcbd_pkg::KIND_ERR, 8'h00, e);
  endfunction

  function automatic int hex_val(logic [7:0] c);
    if (c >= "0" && c <= "9") return int'(c - "0");
    if (c >= "a" && c <= "f") return int'(c - "a") + 10;
    if (c >= "A" && c <= "F") return int'(c - "A") + 10;
    return -1;
  endfunction

  // one byte of the size digits
  function automatic void size_char(logic [7:0] c);
    int v;
    v = hex_val(c);
    if (v >= 0) begin
      if (size_acc > ACC_SHIFT_MAX) begin
        pend_err = hcbd_pkg::ERR_BAD_SIZE;
      end else begin
        size_acc   = {size_acc[ACC_W-5:0], v[3:0]};
        have_digit = 1'b1;
      end
    end else if (c == ";") begin
      st = S_EXT;
    end else if (c == CH_CR) begin
      st = S_HEX_CR;
    end else begin
      pend_err = hcbd_pkg::ERR_BAD_SIZE;
    end
  endfunction

  // advance the local copy by one accepted item; 1 when a result follows
  function automatic logic decode_step(input hcbd_pkg::item_t it,
                                       output hcbd_pkg::result_t r);
    logic [7:0]       c;
    logic [ACC_W-1:0] sz;
    int unsigned      lim;
    c = it.in_byte;
    r = NO_RES;
    if (st == S_DONE || st == S_ERR) return 1'b0;
    if (it.action == hcbd_pkg::ACT_CLOSE) begin
      r = abort(hcbd_pkg::ERR_EOF);
      return 1'b1;
    end
    case (st)
      S_DATA: begin
        if (body_total != TOTAL_MAX) body_total = body_total + 1'b1;
        if (chunk_left != 0) chunk_left = chunk_left - 1'b1;
        if (chunk_left == 0) st = S_END1;
        r = make_res(hcbd_pkg::KIND_DATA, c, hcbd_pkg::ERR_NONE);
        return 1'b1;
      end
      S_END1: begin
        pend_err = (c == CH_CR) ? hcbd_pkg::ERR_NONE : hcbd_pkg::ERR_CRLF;
        st = S_END2;
        return 1'b0;
      end
      S_END2: begin
        if (pend_err != hcbd_pkg::ERR_NONE || c != CH_LF) begin
          r = abort(hcbd_pkg::ERR_CRLF);
          return 1'b1;
        end
        start_line();
        st = S_HEX;
        return 1'b0;
      end
      default: ;
    endcase

    // end of a size line
    if (c == CH_LF && (st == S_HEX_CR || st == S_EXT_CR)) begin
      sz = size_acc;
      if (pend_err != hcbd_pkg::ERR_NONE || !have_digit) begin
        r = abort(hcbd_pkg::ERR_BAD_SIZE);
        return 1'b1;
      end
      start_line();
      if (sz == 0) begin
        st = S_TRL;
        return 1'b0;
      end
      if (body_limit != 0 && (body_total > body_limit ||
          sz > (64'(body_limit) - 64'(body_total)))) begin
        r = abort(hcbd_pkg::ERR_TOO_BIG);
        return 1'b1;
      end
      chunk_left = sz;
      st = S_DATA;
      return 1'b0;
    end

    // end of a trailer line
    if (c == CH_LF && st == S_TRL_CR) begin
      if (!trl_content) begin
        st = S_DONE;
        r = make_res(hcbd_pkg::KIND_DONE, 8'h00, hcbd_pkg::ERR_NONE);
        return 1'b1;
      end
      start_line();
      st = S_TRL;
      return 1'b0;
    end

    // plain line content
    lim = (st == S_TRL || st == S_TRL_CR) ? TRAILER_LINE_MAX : SIZE_LINE_MAX;
    line_len++;
    if (line_len > lim) begin
      r = abort(hcbd_pkg::ERR_LINE);
      return 1'b1;
    end
    case (st)
      S_HEX_CR: begin
        pend_err = hcbd_pkg::ERR_BAD_SIZE;
        st = S_HEX;
        size_char(c);
      end
      S_HEX: size_char(c);
      S_EXT, S_EXT_CR: st = (c == CH_CR) ? S_EXT_CR : S_EXT;
      S_TRL_CR: begin
        trl_content = 1'b1;
        st = (c == CH_CR) ? S_TRL_CR : S_TRL;
      end
      default: begin
        if (c == CH_CR) st = S_TRL_CR;
        else trl_content = 1'b1;
      end
    endcase
    return 1'b0;
  endfunction

  // offer one item in bursts with random gaps, return at its transfer
  task automatic offer(input hcbd_pkg::item_t it);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_if.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 150)
                                               : $urandom_range(1, 24);
    end
    burst_left--;
    in_if.valid   <= 1'b1;
    in_if.action  <= it.action;
    in_if.in_byte <= it.in_byte;
    do @(posedge clk_i); while (!in_if.ready);
    items_sent++;
  endtask

  task automatic send(input hcbd_pkg::item_t it);
    hcbd_pkg::result_t r;
    offer(it);
    if (decode_step(it, r)) note_result(r);
  endtask

  task automatic send_byte(input logic [7:0] b);
    send({hcbd_pkg::ACT_BYTE, b});
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  task automatic end_line();
    send_byte(CH_CR);
    send_byte(CH_LF);
  endtask

  // size line with optional leading zeros, mixed-case digits and extension
  task automatic send_size_line(input logic [ACC_W-1:0] sz, input logic ext);
    string      h;
    logic [7:0] c;
    logic [7:0] prev;
    h = $sformatf("%0h", sz);
    repeat ($urandom_range(0, 2)) send_byte("0");
    for (int i = 0; i < h.len(); i++) begin
      c = h[i];
      if (c >= "a" && c <= "f" && $urandom_range(0, 1) == 1) c = c - 8'h20;
      send_byte(c);
    end
    if (ext) begin
      send_byte(";");
      prev = 8'h00;
      repeat ($urandom_range(0, 8)) begin
        c = 8'($urandom);
        if (prev == CH_CR && c == CH_LF) c = "x";
        send_byte(c);
        prev = c;
      end
    end
    end_line();
  endtask

  // whole chunk; bad_end 1 spoils the CR, 2 spoils the LF
  task automatic send_chunk(input int unsigned sz, input int unsigned bad_end);
    logic [7:0] b;
    send_size_line(ACC_W'(sz), $urandom_range(0, 2) == 0);
    repeat (sz) send_byte(8'($urandom));
    b = 8'($urandom);
    case (bad_end)
      1: begin
        if (b == CH_CR) b = 8'h00;
        send_byte(b);
        send_byte(CH_LF);
      end
      2: begin
        if (b == CH_LF) b = 8'h00;
        send_byte(CH_CR);
        send_byte(b);
      end
      default: end_line();
    endcase
  endtask

  // stop offering, let every result come out and the pipe settle
  task automatic quiesce();
    in_if.valid <= 1'b0;
    burst_left = 0;
    while (body_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_limit(input logic [TOTAL_W-1:0] v);
    cfg_if.valid          <= 1'b1;
    cfg_if.max_body_bytes <= v;
    do @(posedge clk_i); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    body_limit = v;
  endtask

  // well-formed chunks under one limit setting
  task automatic run_phase(input logic [TOTAL_W-1:0] lim, input int unsigned n_items);
    int unsigned        stop_at;
    int unsigned        sz;
    logic [TOTAL_W-1:0] room;
    quiesce();
    write_limit(lim);
    stop_at = items_sent + n_items;
    while (items_sent < stop_at) begin
      sz = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 48) : $urandom_range(1, 10);
      if (body_limit != 0) begin
        room = (body_total >= body_limit) ? '0 : body_limit - body_total;
        if (room == 0) break;
        if (sz > room) sz = int'(room);
      end
      send_chunk(sz, 0);
    end
  endtask

  // the one way this message ends: completion or one of the errors
  task automatic end_stream();
    int unsigned v;
    int unsigned k;
    v = $urandom_range(0, 3);
    case ($urandom_range(0, 5))
      0: begin
        // last chunk, trailer lines with lone CRs, empty line
        send_size_line('0, $urandom_range(0, 1) == 1);
        repeat ($urandom_range(0, 3)) begin
          repeat ($urandom_range(1, 12)) begin
            if ($urandom_range(0, 5) == 0) send_byte(CH_CR);
            send_byte(8'($urandom_range(32, 126)));
          end
          end_line();
        end
        end_line();
      end
      1: begin
        // bad size line
        case (v)
          0: send_text("1g");
          1: if ($urandom_range(0, 1) == 1) send_text(";x");
          2: begin
            send_byte("1");
            send_byte(CH_CR);
            send_byte("X");
          end
          default: repeat (17) send_byte("f");
        endcase
        end_line();
      end
      2: send_chunk($urandom_range(1, 6), $urandom_range(1, 2));
      3: begin
        // body limit exceeded
        quiesce();
        case (v)
          0: begin
            k = $urandom_range(1, 50);
            write_limit(body_total + k);
            send_size_line(ACC_W'(k + 1), $urandom_range(0, 1) == 1);
          end
          1: begin
            write_limit(48'd1);
            send_size_line(ACC_W'($urandom_range(1, 9)), 1'b0);
          end
          default: begin
            write_limit(body_total + $urandom_range(1, 1000));
            send_size_line('1, 1'b0);
          end
        endcase
      end
      4: begin
        // size line over its limit, in the digits or in the extension
        if (v == 0) begin
          repeat (SIZE_LINE_MAX + 1) send_byte("0");
        end else begin
          send_text("1;");
          repeat (SIZE_LINE_MAX + 6) send_byte("a");
        end
      end
      default: begin
        // connection closed early
        case (v)
          0: ;
          1: begin
            send_size_line(ACC_W'(5), 1'b0);
            repeat ($urandom_range(0, 4)) send_byte(8'($urandom));
          end
          default: begin
            send_size_line('0, 1'b0);
            send_text("X-a");
          end
        endcase
        send({hcbd_pkg::ACT_CLOSE, 8'($urandom)});
      end
    endcase
  endtask

  // receiver: stall pattern, one long hold-off, result check
  int unsigned rx_mode   = 0;
  int unsigned rx_left   = 0;
  int unsigned hold_left = 0;
  logic        hold_done = 1'b0;

  always @(posedge clk_i) begin
    hcbd_pkg::result_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      results_seen++;
      if (body_q.size() == 0) begin
        $display("%0t: unexpected transfer kind=%0d byte=%02h err=%0d total=%0d",
                 $time, out_if.kind, out_if.out_byte, out_if.error_code,
                 out_if.total_bytes);
        errors++;
      end else begin
        want = body_q.pop_front();
        if (out_if.kind !== want.kind) begin
          $display("%0t: kind expected %0d actual %0d", $time, want.kind, out_if.kind);
          errors++;
        end
        if (out_if.out_byte !== want.out_byte) begin
          $display("%0t: out_byte expected %02h actual %02h", $time, want.out_byte,
                   out_if.out_byte);
          errors++;
        end
        if (out_if.error_code !== want.error_code) begin
          $display("%0t: error_code expected %0d actual %0d", $time, want.error_code,
                   out_if.error_code);
          errors++;
        end
        if (out_if.total_bytes !== want.total_bytes) begin
          $display("%0t: total_bytes expected %0d actual %0d", $time, want.total_bytes,
                   out_if.total_bytes);
          errors++;
        end
      end
    end
    if (!hold_done && results_seen >= 120) begin
      hold_left = 90;
      hold_done = 1'b1;
    end
    if (rx_left == 0) begin
      rx_mode = $urandom_range(0, 3);
      rx_left = $urandom_range(5, 40);
    end
    rx_left--;
    if (hold_left > 0) begin
      hold_left--;
      out_if.ready <= 1'b0;
    end else begin
      case (rx_mode)
        0: out_if.ready <= 1'b1;
        1: out_if.ready <= ($urandom_range(0, 1) == 1);
        2: out_if.ready <= ($urandom_range(0, 3) == 0);
        default: out_if.ready <= ($urandom_range(0, 7) != 0);
      endcase
    end
  end

  // stimulus sequence
  initial begin
    hcbd_pkg::result_t r;
    logic              got;
    rst_ni                = 1'b0;
    in_if.valid           = 1'b0;
    in_if.action          = hcbd_pkg::ACT_BYTE;
    in_if.in_byte         = 8'h00;
    cfg_if.valid          = 1'b0;
    cfg_if.max_body_bytes = '0;
    st                    = S_HEX;
    chunk_left            = '0;
    body_total            = '0;
    body_limit            = '0;
    start_line();

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed rows under the largest limit
    write_limit(TOTAL_MAX);
    foreach (dir_tab[i]) begin
      offer(dir_tab[i].stim);
      got = decode_step(dir_tab[i].stim, r);
      if (!dir_tab[i].typed) begin
        if (got) note_result(r);
      end else if (dir_tab[i].has_res) begin
        note_result(dir_tab[i].res);
      end
    end

    // random chunks under several limits
    run_phase('0, 150);
    run_phase(body_total + $urandom_range(40, 90), 150);
    run_phase({1'b1, 15'($urandom), 32'($urandom)}, 150);
    run_phase('0, 150);

    end_stream();

    // the block is finished; these must be ignored
    repeat (8) send({1'($urandom), 8'($urandom)});

    in_if.valid <= 1'b0;
    while (body_q.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (errors == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

  // run time limit
  initial begin
    #20_000_000;
    $display("tb_top: errors");
    $finish;
  end

endmodule
